### rtl/core/plcfb_pkg.sv
// Shared types, protocol codes and defaults for the PLC command frame builder.
package plcfb_pkg;

  // Default sizing of the transfer splitter and the job queue.
  localparam int unsigned MAX_TRANSFER_BYTES_DEF = 128;
  localparam int unsigned MAX_ELEMENTS_DEF       = 8192;
  localparam int unsigned QUEUE_DEPTH_DEF        = 2;

  // Header buffer geometry: the longest frame is twelve bytes.
  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);

  localparam logic [HDR_IDX_W-1:0] LAST_IDX_SINGLE  = HDR_IDX_W'(0);
  localparam logic [HDR_IDX_W-1:0] LAST_IDX_TEST    = HDR_IDX_W'(7);
  localparam logic [HDR_IDX_W-1:0] LAST_IDX_SPECIAL = HDR_IDX_W'(9);
  localparam logic [HDR_IDX_W-1:0] LAST_IDX_DEVICE  = HDR_IDX_W'(11);

  // Command and response codes.
  localparam logic [7:0] CMD_TEST     = 8'h51;
  localparam logic [7:0] RSP_TEST     = 8'hD1;
  localparam logic [7:0] CMD_BIT_RD   = 8'h01;
  localparam logic [7:0] CMD_BIT_WR   = 8'h02;
  localparam logic [7:0] CMD_WORD_RD  = 8'h11;
  localparam logic [7:0] CMD_WORD_WR  = 8'h12;
  localparam logic [7:0] CMD_SPEC_RD  = 8'h31;
  localparam logic [7:0] CMD_SPEC_WR  = 8'h32;
  localparam logic [7:0] RSP_BIT_RD   = 8'h81;
  localparam logic [7:0] RSP_BIT_WR   = 8'h82;
  localparam logic [7:0] RSP_WORD_RD  = 8'h91;
  localparam logic [7:0] RSP_WORD_WR  = 8'h92;
  localparam logic [7:0] RSP_SPEC_RD  = 8'hB1;
  localparam logic [7:0] RSP_SPEC_WR  = 8'hB2;

  // Length field of the test frame and the data count of its answer.
  localparam logic [15:0] TEST_FOLLOW_LEN  = 16'h0004;
  localparam logic [15:0] TEST_REPLY_COUNT = 16'h0004;

  // Fixed part of the follow count for the two command formats.
  localparam logic [16:0] FOLLOW_BASE_DEVICE  = 17'd8;
  localparam logic [16:0] FOLLOW_BASE_SPECIAL = 17'd6;

  localparam logic [16:0] BYTES_SAT = 17'h1FFFF;

  // Request kinds.
  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_NOT_DONE  = 3'd1,
    VERDICT_NOT_MINE  = 3'd2,
    VERDICT_ERROR     = 3'd3,
    VERDICT_RECOVERED = 3'd4
  } verdict_e;

  typedef enum logic [2:0] {
    REG_CPU_NUMBER     = 3'd0,
    REG_DEVICE_CLASS   = 3'd1,
    REG_BASE_ADDRESS   = 3'd2,
    REG_ACCESS_WIDTH   = 3'd3,
    REG_SPECIAL_MODULE = 3'd4,
    REG_MODULE_UNIT    = 3'd5,
    REG_MODULE_SLOT    = 3'd6,
    REG_IS_WRITE       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        req_type;
    logic [13:0] element_count;
    logic        start_transfer;
    logic        recovering;
    logic [31:0] recovery_sequence;
    logic [7:0]  resp_code;
    logic [7:0]  resp_status;
    logic [15:0] resp_count;
    logic [31:0] resp_sequence;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_last;
    logic [2:0]  verdict;
    logic [7:0]  chunk_bytes;
    logic [16:0] chunk_offset;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  cpu_number;
    logic [7:0]  device_class;
    logic [31:0] base_address;
    logic [3:0]  access_width;
    logic        special_module;
    logic [7:0]  module_unit;
    logic [4:0]  module_slot;
    logic        is_write;
  } cfg_t;

  // One classified item on its way to the serializer.
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [HDR_IDX_W-1:0]      last_idx;
    verdict_e                  verdict;
    logic [7:0]                chunk_bytes;
    logic [16:0]               chunk_offset;
  } job_t;

endpackage

### rtl/core/plcfb_front.sv
// Front end: accepts items, tracks chunk state and classifies each item into a job.
module plcfb_front #(
  parameter int unsigned MAX_TRANSFER_BYTES = plcfb_pkg::MAX_TRANSFER_BYTES_DEF,
  parameter int unsigned MAX_ELEMENTS       = plcfb_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plcfb_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plcfb_pkg::in_item_t in_data_i,
  input  logic                full_i,
  output logic                push_o,
  output plcfb_pkg::job_t     job_o
);

  localparam logic [16:0] MaxBytes = 17'(MAX_TRANSFER_BYTES);
  localparam logic [15:0] MaxElems = 16'(MAX_ELEMENTS);

  logic [16:0] byte_offset_q, byte_offset_d;
  logic [16:0] bytes_left_q, bytes_left_d;

  logic        accept;
  logic [15:0] count_ext, count_clamp;
  logic [19:0] product;
  logic [16:0] nbytes, off0, bl_sel, nread, nwrite, dev_off, npt, follow;
  logic [31:0] addr;
  logic        chunked, width_ok, bit_dev;
  logic [7:0]  exp_code;
  logic [15:0] exp_count;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Transfer size, clamped in elements and saturated in bytes.
  always_comb begin
    count_ext   = {2'b00, in_data_i.element_count};
    count_clamp = (count_ext > MaxElems) ? MaxElems : count_ext;
    product     = 20'(cfg_i.access_width) * 20'(count_clamp);
    nbytes      = (|product[19:17]) ? plcfb_pkg::BYTES_SAT : product[16:0];
  end

  // Chunk sizing and header field arithmetic shared by both request kinds.
  always_comb begin
    off0     = in_data_i.start_transfer ? '0 : byte_offset_q;
    width_ok = cfg_i.access_width inside {4'd1, 4'd2, 4'd4, 4'd8};
    chunked  = nbytes > MaxBytes;
    bl_sel   = (in_data_i.req_type == plcfb_pkg::REQ_BUILD && chunked && off0 == '0)
               ? nbytes : bytes_left_q;
    nread    = chunked ? ((bl_sel > MaxBytes) ? MaxBytes : bl_sel) : nbytes;
    nwrite   = cfg_i.is_write ? nread : '0;
    bit_dev  = !cfg_i.special_module && cfg_i.access_width == 4'd1;
    dev_off  = bit_dev ? off0 : {1'b0, off0[16:1]};
    npt      = bit_dev ? nread : {1'b0, nread[16:1]};
    addr     = cfg_i.base_address + {15'b0, dev_off};
    follow   = (cfg_i.special_module ? plcfb_pkg::FOLLOW_BASE_SPECIAL
                                     : plcfb_pkg::FOLLOW_BASE_DEVICE) + nwrite;
    exp_count = cfg_i.is_write ? 16'h0000 : nread[15:0];
    if (cfg_i.special_module) begin
      exp_code = cfg_i.is_write ? plcfb_pkg::RSP_SPEC_WR : plcfb_pkg::RSP_SPEC_RD;
    end else if (bit_dev) begin
      exp_code = cfg_i.is_write ? plcfb_pkg::RSP_BIT_WR : plcfb_pkg::RSP_BIT_RD;
    end else begin
      exp_code = cfg_i.is_write ? plcfb_pkg::RSP_WORD_WR : plcfb_pkg::RSP_WORD_RD;
    end
  end

  // Classification: build the job and the next chunk state.
  always_comb begin
    job_o         = '0;
    job_o.verdict = plcfb_pkg::VERDICT_OK;
    bytes_left_d  = bytes_left_q;
    byte_offset_d = off0;
    if (in_data_i.recovering && in_data_i.req_type == plcfb_pkg::REQ_BUILD) begin
      // Test frame carrying the recovery sequence number.
      job_o.hdr[0]   = plcfb_pkg::CMD_TEST;
      job_o.hdr[1]   = cfg_i.cpu_number;
      job_o.hdr[2]   = plcfb_pkg::TEST_FOLLOW_LEN[15:8];
      job_o.hdr[3]   = plcfb_pkg::TEST_FOLLOW_LEN[7:0];
      job_o.hdr[4]   = in_data_i.recovery_sequence[31:24];
      job_o.hdr[5]   = in_data_i.recovery_sequence[23:16];
      job_o.hdr[6]   = in_data_i.recovery_sequence[15:8];
      job_o.hdr[7]   = in_data_i.recovery_sequence[7:0];
      job_o.last_idx = plcfb_pkg::LAST_IDX_TEST;
    end else if (in_data_i.recovering) begin
      // Only the test frame answer counts while the link recovers.
      job_o.last_idx = plcfb_pkg::LAST_IDX_SINGLE;
      if (in_data_i.resp_code != plcfb_pkg::RSP_TEST ||
          in_data_i.resp_count != plcfb_pkg::TEST_REPLY_COUNT ||
          in_data_i.resp_sequence != in_data_i.recovery_sequence) begin
        job_o.verdict = plcfb_pkg::VERDICT_NOT_MINE;
      end else begin
        job_o.verdict = plcfb_pkg::VERDICT_RECOVERED;
      end
    end else if (!cfg_i.special_module && !width_ok) begin
      job_o.last_idx = plcfb_pkg::LAST_IDX_SINGLE;
      job_o.verdict  = plcfb_pkg::VERDICT_ERROR;
    end else if (in_data_i.req_type == plcfb_pkg::REQ_BUILD) begin
      job_o.hdr[1]       = cfg_i.cpu_number;
      job_o.hdr[2]       = follow[15:8];
      job_o.hdr[3]       = follow[7:0];
      job_o.chunk_bytes  = nread[7:0];
      job_o.chunk_offset = off0;
      bytes_left_d       = bl_sel;
      if (cfg_i.special_module) begin
        job_o.hdr[0]   = cfg_i.is_write ? plcfb_pkg::CMD_SPEC_WR : plcfb_pkg::CMD_SPEC_RD;
        job_o.hdr[4]   = cfg_i.module_unit;
        job_o.hdr[5]   = {3'b000, cfg_i.module_slot};
        job_o.hdr[6]   = addr[15:8];
        job_o.hdr[7]   = addr[7:0];
        job_o.hdr[8]   = npt[15:8];
        job_o.hdr[9]   = npt[7:0];
        job_o.last_idx = plcfb_pkg::LAST_IDX_SPECIAL;
      end else begin
        if (bit_dev) begin
          job_o.hdr[0] = cfg_i.is_write ? plcfb_pkg::CMD_BIT_WR : plcfb_pkg::CMD_BIT_RD;
        end else begin
          job_o.hdr[0] = cfg_i.is_write ? plcfb_pkg::CMD_WORD_WR : plcfb_pkg::CMD_WORD_RD;
        end
        job_o.hdr[4]   = 8'h00;
        job_o.hdr[5]   = cfg_i.device_class;
        job_o.hdr[6]   = addr[31:24];
        job_o.hdr[7]   = addr[23:16];
        job_o.hdr[8]   = addr[15:8];
        job_o.hdr[9]   = addr[7:0];
        job_o.hdr[10]  = npt[15:8];
        job_o.hdr[11]  = npt[7:0];
        job_o.last_idx = plcfb_pkg::LAST_IDX_DEVICE;
      end
    end else begin
      // Reply header check; a passing reply advances the chunk state.
      job_o.last_idx     = plcfb_pkg::LAST_IDX_SINGLE;
      job_o.chunk_bytes  = nread[7:0];
      job_o.chunk_offset = off0;
      if (in_data_i.resp_code != exp_code) begin
        job_o.verdict = plcfb_pkg::VERDICT_NOT_MINE;
      end else if (in_data_i.resp_status != 8'h00) begin
        job_o.verdict = plcfb_pkg::VERDICT_ERROR;
      end else if (in_data_i.resp_count != exp_count) begin
        job_o.verdict = plcfb_pkg::VERDICT_NOT_MINE;
      end else begin
        job_o.verdict = (chunked && bytes_left_q > MaxBytes)
                        ? plcfb_pkg::VERDICT_NOT_DONE : plcfb_pkg::VERDICT_OK;
        bytes_left_d  = (bytes_left_q > nread) ? (bytes_left_q - nread) : '0;
        byte_offset_d = off0 + nread;
      end
    end
  end

  // Chunk state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      bytes_left_q  <= '0;
    end else if (accept) begin
      byte_offset_q <= byte_offset_d;
      bytes_left_q  <= bytes_left_d;
    end
  end

endmodule

### rtl/core/plcfb_fifo.sv
// Short job queue between the front end and the serializer.
module plcfb_fifo #(
  parameter int unsigned DEPTH = plcfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  plcfb_pkg::job_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output plcfb_pkg::job_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  plcfb_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == FullCnt;
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/plcfb_back.sv
// Back end: serializes each queued job into result transactions, one per cycle unless stalled.
module plcfb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  plcfb_pkg::job_t      job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output plcfb_pkg::out_item_t out_data_o
);

  logic [plcfb_pkg::HDR_IDX_W-1:0] idx_q;
  logic                            out_valid_q;
  plcfb_pkg::out_item_t            out_q, out_d;
  logic                            load, at_last;

  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign at_last     = idx_q == job_i.last_idx;
  assign pop_o       = load && at_last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next result taken from the head job.
  always_comb begin
    out_d.out_byte     = job_i.hdr[idx_q];
    out_d.is_last      = at_last;
    out_d.verdict      = job_i.verdict;
    out_d.chunk_bytes  = job_i.chunk_bytes;
    out_d.chunk_offset = job_i.chunk_offset;
  end

  // Byte index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= at_last ? '0 : idx_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

### rtl/core/plc_command_frame_builder_unit.sv
// An accepted item is written into the job queue; its results are registered in the output
// serializer. Throughput: one result per cycle while out_ready_i is high; a build gives
// 12 results (10 special, 8 test frame), and a reply check or an error a single result.
// The front end takes a new item each cycle while the job queue (QUEUE_DEPTH entries, two by default) has room.
// Reset clears the chunk state and the queue and loads the registers with their defaults.
// Top level: configuration registers, front end, job queue and serializer.
module plc_command_frame_builder_unit #(
  parameter int unsigned MAX_TRANSFER_BYTES = plcfb_pkg::MAX_TRANSFER_BYTES_DEF,
  parameter int unsigned MAX_ELEMENTS       = plcfb_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned QUEUE_DEPTH        = plcfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  plcfb_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output plcfb_pkg::out_item_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  plcfb_pkg::cfg_t    cfg_q;
  plcfb_pkg::reg_idx_e reg_idx;
  logic               cfg_write;
  logic               push, full, pop, job_valid;
  plcfb_pkg::job_t    job_in, job_out;

  assign pready    = 1'b1;
  assign reg_idx   = plcfb_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpu_number     <= 8'd1;
      cfg_q.device_class   <= 8'd0;
      cfg_q.base_address   <= 32'd0;
      cfg_q.access_width   <= 4'd2;
      cfg_q.special_module <= 1'b0;
      cfg_q.module_unit    <= 8'd0;
      cfg_q.module_slot    <= 5'd1;
      cfg_q.is_write       <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        plcfb_pkg::REG_CPU_NUMBER:     cfg_q.cpu_number     <= pwdata[7:0];
        plcfb_pkg::REG_DEVICE_CLASS:   cfg_q.device_class   <= pwdata[7:0];
        plcfb_pkg::REG_BASE_ADDRESS:   cfg_q.base_address   <= pwdata;
        plcfb_pkg::REG_ACCESS_WIDTH:   cfg_q.access_width   <= pwdata[3:0];
        plcfb_pkg::REG_SPECIAL_MODULE: cfg_q.special_module <= pwdata[0];
        plcfb_pkg::REG_MODULE_UNIT:    cfg_q.module_unit    <= pwdata[7:0];
        plcfb_pkg::REG_MODULE_SLOT:    cfg_q.module_slot    <= pwdata[4:0];
        plcfb_pkg::REG_IS_WRITE:       cfg_q.is_write       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_idx)
      plcfb_pkg::REG_CPU_NUMBER:     prdata = {24'b0, cfg_q.cpu_number};
      plcfb_pkg::REG_DEVICE_CLASS:   prdata = {24'b0, cfg_q.device_class};
      plcfb_pkg::REG_BASE_ADDRESS:   prdata = cfg_q.base_address;
      plcfb_pkg::REG_ACCESS_WIDTH:   prdata = {28'b0, cfg_q.access_width};
      plcfb_pkg::REG_SPECIAL_MODULE: prdata = {31'b0, cfg_q.special_module};
      plcfb_pkg::REG_MODULE_UNIT:    prdata = {24'b0, cfg_q.module_unit};
      plcfb_pkg::REG_MODULE_SLOT:    prdata = {27'b0, cfg_q.module_slot};
      plcfb_pkg::REG_IS_WRITE:       prdata = {31'b0, cfg_q.is_write};
      default:                       prdata = '0;
    endcase
  end

  plcfb_front #(
    .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES),
    .MAX_ELEMENTS      (MAX_ELEMENTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  plcfb_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .data_o (job_out)
  );

  plcfb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job pushed into a full queue");

  // An accepted item leaves a job waiting in the queue on the next cycle.
  a_job_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> job_valid)
    else $error("accepted item did not reach the queue");

  // A verdict other than ok only ever comes on a single, last result.
  a_single_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.verdict != plcfb_pkg::VERDICT_OK) |-> out_data_o.is_last)
    else $error("non-ok verdict on a result that is not the last");
`endif

endmodule

### tb/sv/plc_command_frame_builder_checker.sv
// Scoreboard for the PLC command frame builder: tracks registers, predicts and checks results.
module plc_command_frame_builder_checker
  import plcfb_pkg::*;
#(
  parameter int unsigned MAX_TRANSFER_BYTES = MAX_TRANSFER_BYTES_DEF,
  parameter int unsigned MAX_ELEMENTS       = MAX_ELEMENTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatch_count_o,
  output int          results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the registers and of the chunk tracker.
  cfg_t        cfg_q;
  logic [16:0] left_q;
  logic [16:0] offset_q;
  out_item_t   due_results[$];
  int          mismatch_count;

  // Transfer size in bytes, with the element limit and the byte saturation applied.
  function automatic logic [16:0] transfer_size(input logic [13:0] count);
    logic [31:0] elems;
    logic [31:0] total;
    elems = (count > MAX_ELEMENTS) ? 32'(MAX_ELEMENTS) : 32'(count);
    total = elems * 32'(cfg_q.access_width);
    return (total > 32'(BYTES_SAT)) ? BYTES_SAT : total[16:0];
  endfunction

  task automatic push_result(input logic [7:0] b, input logic last, input verdict_e vd,
                             input logic [16:0] nbytes, input logic [16:0] offset);
    out_item_t r;
    r.out_byte     = b;
    r.is_last      = last;
    r.verdict      = vd;
    r.chunk_bytes  = nbytes[7:0];
    r.chunk_offset = offset;
    due_results.push_back(r);
  endtask

  // Works out the frame bytes or the reply verdict for one transaction.
  task automatic derive_results(input in_item_t item);
    logic [16:0] nbytes, nread, nwrite, fol, npt, off, co;
    logic [31:0] addr;
    logic [7:0]  hdr [HDR_BYTES];
    int          nhdr;
    logic        bit_dev, width_ok;
    verdict_e    vd;
    logic [7:0]  want_code;
    logic [15:0] want_count;

    width_ok = cfg_q.access_width inside {4'd1, 4'd2, 4'd4, 4'd8};
    bit_dev  = (cfg_q.access_width == 4'd1);
    if (item.start_transfer) begin
      offset_q = '0;
    end

    if (item.req_type == REQ_BUILD && item.recovering) begin
      // Test frame while the link recovers.
      hdr[0] = CMD_TEST;
      hdr[1] = cfg_q.cpu_number;
      hdr[2] = TEST_FOLLOW_LEN[15:8];
      hdr[3] = TEST_FOLLOW_LEN[7:0];
      hdr[4] = item.recovery_sequence[31:24];
      hdr[5] = item.recovery_sequence[23:16];
      hdr[6] = item.recovery_sequence[15:8];
      hdr[7] = item.recovery_sequence[7:0];
      for (int i = 0; i < 8; i++) begin
        push_result(hdr[i], i == 7, VERDICT_OK, '0, '0);
      end
    end else if (item.req_type == REQ_CHECK && item.recovering) begin
      // Only the test-frame answer counts during recovery.
      if (item.resp_code != RSP_TEST || item.resp_count != TEST_REPLY_COUNT ||
          item.resp_sequence != item.recovery_sequence) begin
        push_result(8'h00, 1'b1, VERDICT_NOT_MINE, '0, '0);
      end else begin
        push_result(8'h00, 1'b1, VERDICT_RECOVERED, '0, '0);
      end
    end else if (!cfg_q.special_module && !width_ok) begin
      push_result(8'h00, 1'b1, VERDICT_ERROR, '0, '0);
    end else begin
      // Chunk size, loading the byte count at the start of a split transfer.
      nbytes = transfer_size(item.element_count);
      nread  = nbytes;
      vd     = VERDICT_OK;
      if (nbytes > MAX_TRANSFER_BYTES) begin
        if (item.req_type == REQ_BUILD && offset_q == '0) begin
          left_q = nbytes;
        end
        nread = (left_q > MAX_TRANSFER_BYTES) ? 17'(MAX_TRANSFER_BYTES) : left_q;
        if (left_q > MAX_TRANSFER_BYTES) begin
          vd = VERDICT_NOT_DONE;
        end
      end

      if (item.req_type == REQ_BUILD) begin
        nwrite = cfg_q.is_write ? nread : '0;
        if (!cfg_q.special_module) begin
          fol  = FOLLOW_BASE_DEVICE + nwrite;
          off  = bit_dev ? offset_q : (offset_q >> 1);
          npt  = bit_dev ? nread : (nread >> 1);
          addr = cfg_q.base_address + 32'(off);
          if (bit_dev) begin
            hdr[0] = cfg_q.is_write ? CMD_BIT_WR : CMD_BIT_RD;
          end else begin
            hdr[0] = cfg_q.is_write ? CMD_WORD_WR : CMD_WORD_RD;
          end
          hdr[1]  = cfg_q.cpu_number;
          hdr[2]  = fol[15:8];
          hdr[3]  = fol[7:0];
          hdr[4]  = 8'h00;
          hdr[5]  = cfg_q.device_class;
          hdr[6]  = addr[31:24];
          hdr[7]  = addr[23:16];
          hdr[8]  = addr[15:8];
          hdr[9]  = addr[7:0];
          hdr[10] = npt[15:8];
          hdr[11] = npt[7:0];
          nhdr    = 12;
        end else begin
          fol    = FOLLOW_BASE_SPECIAL + nwrite;
          off    = offset_q >> 1;
          npt    = nread >> 1;
          addr   = cfg_q.base_address + 32'(off);
          hdr[0] = cfg_q.is_write ? CMD_SPEC_WR : CMD_SPEC_RD;
          hdr[1] = cfg_q.cpu_number;
          hdr[2] = fol[15:8];
          hdr[3] = fol[7:0];
          hdr[4] = cfg_q.module_unit;
          hdr[5] = 8'(cfg_q.module_slot);
          hdr[6] = addr[15:8];
          hdr[7] = addr[7:0];
          hdr[8] = npt[15:8];
          hdr[9] = npt[7:0];
          nhdr   = 10;
        end
        for (int i = 0; i < nhdr; i++) begin
          push_result(hdr[i], i == nhdr - 1, VERDICT_OK, nread, offset_q);
        end
      end else begin
        // Reply check: code first, then status, then data count.
        if (cfg_q.special_module) begin
          want_code = cfg_q.is_write ? RSP_SPEC_WR : RSP_SPEC_RD;
        end else if (bit_dev) begin
          want_code = cfg_q.is_write ? RSP_BIT_WR : RSP_BIT_RD;
        end else begin
          want_code = cfg_q.is_write ? RSP_WORD_WR : RSP_WORD_RD;
        end
        want_count = cfg_q.is_write ? 16'h0000 : nread[15:0];
        co = offset_q;
        if (item.resp_code != want_code) begin
          vd = VERDICT_NOT_MINE;
        end else if (item.resp_status != 8'h00) begin
          vd = VERDICT_ERROR;
        end else if (item.resp_count != want_count) begin
          vd = VERDICT_NOT_MINE;
        end else begin
          left_q   = (left_q > nread) ? left_q - nread : '0;
          offset_q = offset_q + nread;
        end
        push_result(8'h00, 1'b1, vd, nread, co);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Register writes, input transactions and result transactions, all seen at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg_q.cpu_number     = 8'd1;
      cfg_q.device_class   = 8'd0;
      cfg_q.base_address   = 32'd0;
      cfg_q.access_width   = 4'd2;
      cfg_q.special_module = 1'b0;
      cfg_q.module_unit    = 8'd0;
      cfg_q.module_slot    = 5'd1;
      cfg_q.is_write       = 1'b0;
      left_q               = '0;
      offset_q             = '0;
      mismatch_count       = 0;
      due_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none due, expected nothing, got %p", $time,
                   out_data_i);
        end else begin
          want = due_results.pop_front();
          compare_field("out_byte", 32'(want.out_byte), 32'(out_data_i.out_byte));
          compare_field("is_last", 32'(want.is_last), 32'(out_data_i.is_last));
          compare_field("verdict", 32'(want.verdict), 32'(out_data_i.verdict));
          compare_field("chunk_bytes", 32'(want.chunk_bytes), 32'(out_data_i.chunk_bytes));
          compare_field("chunk_offset", 32'(want.chunk_offset),
                        32'(out_data_i.chunk_offset));
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:2]))
          REG_CPU_NUMBER:     cfg_q.cpu_number     = pwdata_i[7:0];
          REG_DEVICE_CLASS:   cfg_q.device_class   = pwdata_i[7:0];
          REG_BASE_ADDRESS:   cfg_q.base_address   = pwdata_i;
          REG_ACCESS_WIDTH:   cfg_q.access_width   = pwdata_i[3:0];
          REG_SPECIAL_MODULE: cfg_q.special_module = pwdata_i[0];
          REG_MODULE_UNIT:    cfg_q.module_unit    = pwdata_i[7:0];
          REG_MODULE_SLOT:    cfg_q.module_slot    = pwdata_i[4:0];
          REG_IS_WRITE:       cfg_q.is_write       = pwdata_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        derive_results(in_data_i);
      end
    end
    mismatch_count_o = mismatch_count;
    results_due_o    = due_results.size();
  end

endmodule

### tb/sv/plc_command_frame_builder_unit_test.sv
// Testbench top for the PLC command frame builder: stimulus, handshakes and verdict.
module plc_command_frame_builder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import plcfb_pkg::*;

  localparam longint unsigned TIMEOUT_NS  = 64'd30_000_000;
  localparam int              LONG_HOLD   = 300;
  localparam int              SETTLE_CYCS = 20;
  localparam int              NUM_PHASES  = 9;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   mismatch_count;
  int   results_due;
  int   items_sent;
  int   burst_left;
  cfg_t cfg_now;

  plc_command_frame_builder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  plc_command_frame_builder_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Sender gap: mostly none or short, a few long, with runs of back-to-back transactions.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one input transaction and returns at the edge where it is taken.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has been delivered.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_due != 0);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c);
    apb_write(REG_CPU_NUMBER, 32'(c.cpu_number));
    apb_write(REG_DEVICE_CLASS, 32'(c.device_class));
    apb_write(REG_BASE_ADDRESS, c.base_address);
    apb_write(REG_ACCESS_WIDTH, 32'(c.access_width));
    apb_write(REG_SPECIAL_MODULE, 32'(c.special_module));
    apb_write(REG_MODULE_UNIT, 32'(c.module_unit));
    apb_write(REG_MODULE_SLOT, 32'(c.module_slot));
    apb_write(REG_IS_WRITE, 32'(c.is_write));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Register setting of each phase; the first two and the special ones pin the extremes.
  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    c.cpu_number     = 8'($urandom);
    c.device_class   = 8'($urandom);
    c.base_address   = $urandom;
    c.access_width   = 4'($urandom_range(1, 8));
    c.special_module = 1'($urandom_range(0, 1));
    c.module_unit    = 8'($urandom);
    c.module_slot    = 5'($urandom_range(1, 16));
    c.is_write       = 1'($urandom_range(0, 1));
    case (p)
      1: c = '{cpu_number: 8'd0, device_class: 8'd0, base_address: 32'd0,
               access_width: 4'd1, special_module: 1'b0, module_unit: 8'd0,
               module_slot: 5'd1, is_write: 1'b0};
      2: c = '{cpu_number: 8'hFF, device_class: 8'hFF, base_address: 32'hFFFF_FFF0,
               access_width: 4'd8, special_module: 1'b0, module_unit: 8'hFF,
               module_slot: 5'd16, is_write: 1'b1};
      3: begin
        c.access_width = 4'd4; c.special_module = 1'b0; c.is_write = 1'b0;
      end
      4: begin
        c.special_module = 1'b1; c.access_width = 4'd3; c.module_unit = 8'hFF;
        c.module_slot = 5'd16; c.base_address = 32'hFFFF_FFFF; c.is_write = 1'b1;
      end
      5: begin
        c.special_module = 1'b1; c.access_width = 4'd8; c.module_unit = 8'd0;
        c.module_slot = 5'd1; c.is_write = 1'b0;
      end
      6: begin
        c.special_module = 1'b0; c.access_width = 4'd5;
      end
      7: begin
        c.special_module = 1'b0; c.access_width = 4'd1; c.is_write = 1'b1;
      end
      8: begin
        c.special_module = 1'b0; c.access_width = 4'd2; c.is_write = 1'b1;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] good_reply_code(input cfg_t c);
    if (c.special_module) return c.is_write ? RSP_SPEC_WR : RSP_SPEC_RD;
    if (c.access_width == 4'd1) return c.is_write ? RSP_BIT_WR : RSP_BIT_RD;
    return c.is_write ? RSP_WORD_WR : RSP_WORD_RD;
  endfunction

  function automatic in_item_t directed_item(
      input logic req, input logic [13:0] count, input logic start, input logic rec,
      input logic [31:0] seq, input logic [7:0] code, input logic [7:0] status,
      input logic [15:0] rcount, input logic [31:0] rseq);
    in_item_t it;
    it.req_type          = req;
    it.element_count     = count;
    it.start_transfer    = start;
    it.recovering        = rec;
    it.recovery_sequence = seq;
    it.resp_code         = code;
    it.resp_status       = status;
    it.resp_count        = rcount;
    it.resp_sequence     = rseq;
    return it;
  endfunction

  // Unstructured transaction, leaning toward values the block reacts to.
  function automatic in_item_t random_item();
    in_item_t it;
    it.req_type          = 1'($urandom_range(0, 1));
    it.element_count     = ($urandom_range(0, 9) < 7) ? 14'($urandom_range(0, 300))
                                                       : 14'($urandom);
    it.start_transfer    = 1'($urandom_range(0, 1));
    it.recovering        = ($urandom_range(0, 3) == 0);
    it.recovery_sequence = $urandom;
    it.resp_code         = $urandom_range(0, 1) ? good_reply_code(cfg_now) : 8'($urandom);
    it.resp_status       = ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom);
    it.resp_count        = $urandom_range(0, 1) ? 16'($urandom_range(0, 256))
                                                : 16'($urandom);
    it.resp_sequence     = $urandom_range(0, 1) ? it.recovery_sequence : $urandom;
    return it;
  endfunction

  // One whole transfer: build and answer each chunk, with an occasional bad reply or abort.
  task automatic run_transfer();
    in_item_t    it;
    int unsigned w, n_el, total, left, chunk, lim;
    bit          chunked, first, aborted;
    w     = cfg_now.access_width;
    lim   = MAX_TRANSFER_BYTES_DEF / w;
    n_el  = $urandom_range(0, 1) ? $urandom_range(0, lim)
                                 : $urandom_range(lim + 1, 512 / w);
    total = w * n_el;
    chunked = (total > MAX_TRANSFER_BYTES_DEF);
    left    = total;
    first   = 1'b1;
    aborted = 1'b0;
    do begin
      it = random_item();
      it.req_type       = REQ_BUILD;
      it.element_count  = 14'(n_el);
      it.start_transfer = first;
      it.recovering     = 1'b0;
      send_item(it);
      first = 1'b0;
      chunk = chunked ? ((left > MAX_TRANSFER_BYTES_DEF) ? MAX_TRANSFER_BYTES_DEF : left)
                      : total;
      it.req_type    = REQ_CHECK;
      it.resp_code   = good_reply_code(cfg_now);
      it.resp_status = 8'h00;
      it.resp_count  = cfg_now.is_write ? 16'h0000 : 16'(chunk);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: it.resp_code   = it.resp_code ^ 8'h40;
          1: it.resp_status = 8'($urandom_range(1, 255));
          default: it.resp_count = it.resp_count ^ 16'h0001;
        endcase
        send_item(it);
        it.resp_code   = good_reply_code(cfg_now);
        it.resp_status = 8'h00;
        it.resp_count  = cfg_now.is_write ? 16'h0000 : 16'(chunk);
      end
      if ($urandom_range(0, 19) == 0) begin
        aborted = 1'b1;
      end else begin
        send_item(it);
        left = (left > chunk) ? left - chunk : 0;
      end
    end while (!aborted && chunked && left > 0);
  endtask

  // Test frame and its answer, sometimes with a wrong answer.
  task automatic recovery_exchange();
    in_item_t    it;
    logic [31:0] seq;
    seq = $urandom;
    it = random_item();
    it.req_type          = REQ_BUILD;
    it.recovering        = 1'b1;
    it.recovery_sequence = seq;
    send_item(it);
    it.req_type      = REQ_CHECK;
    it.resp_code     = RSP_TEST;
    it.resp_count    = TEST_REPLY_COUNT;
    it.resp_sequence = seq;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: it.resp_code = 8'($urandom);
        1: it.resp_count = 16'($urandom);
        default: it.resp_sequence = seq ^ (32'h1 << $urandom_range(0, 31));
      endcase
    end
    send_item(it);
  endtask

  // Result side: random stalls, calm stretches and one long hold-off under load.
  initial begin : receiver
    int stall_left;
    int calm_left;
    int delivered;
    int r;
    bit long_hold_done;
    stall_left     = 0;
    calm_left      = 0;
    delivered      = 0;
    long_hold_done = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) delivered++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= (stall_left == 0);
      end else if (!long_hold_done && delivered >= 600 && in_valid_i) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready_i <= 1'b1;
        end else if (r < 85) begin
          stall_left = $urandom_range(1, 3);
          out_ready_i <= 1'b0;
        end else if (r < 95) begin
          stall_left = $urandom_range(4, 12);
          out_ready_i <= 1'b0;
        end else if (r < 98) begin
          stall_left = $urandom_range(20, 80);
          out_ready_i <= 1'b0;
        end else begin
          calm_left = $urandom_range(30, 60);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Input side: reset, directed transactions, then one random phase per register setting.
  initial begin : stimulus
    int r;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    items_sent = 0;
    burst_left = 0;
    cfg_now    = '{cpu_number: 8'd1, device_class: 8'd0, base_address: 32'd0,
                   access_width: 4'd2, special_module: 1'b0, module_unit: 8'd0,
                   module_slot: 5'd1, is_write: 1'b0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting is a word read: single frames, the element limit, chunk boundaries.
    send_item(directed_item(REQ_BUILD, 14'd1, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, 14'd1, 1'b0, 1'b0, '0, RSP_WORD_RD, '0, 16'd2, '0));
    send_item(directed_item(REQ_BUILD, 14'd0, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, 14'd0, 1'b0, 1'b0, '0, RSP_WORD_RD, '0, 16'd0, '0));
    send_item(directed_item(REQ_BUILD, 14'h3FFF, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, 14'h3FFF, 1'b0, 1'b0, '0, RSP_WORD_RD, '0,
                            16'd128, '0));
    send_item(directed_item(REQ_CHECK, 14'h3FFF, 1'b0, 1'b0, '0, 8'h00, '0, 16'd128, '0));
    send_item(directed_item(REQ_CHECK, 14'h3FFF, 1'b0, 1'b0, '0, RSP_WORD_RD, 8'hFF,
                            16'd128, '0));
    send_item(directed_item(REQ_CHECK, 14'h3FFF, 1'b0, 1'b0, '0, RSP_WORD_RD, '0,
                            16'hFFFF, '0));
    send_item(directed_item(REQ_BUILD, 14'd64, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, 14'd64, 1'b0, 1'b0, '0, RSP_WORD_RD, '0,
                            16'd128, '0));
    send_item(directed_item(REQ_BUILD, 14'd65, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, 14'd65, 1'b0, 1'b0, '0, RSP_WORD_RD, '0,
                            16'd128, '0));
    send_item(directed_item(REQ_BUILD, 14'd65, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, 14'd65, 1'b0, 1'b0, '0, RSP_WORD_RD, '0, 16'd2, '0));

    // Test frames and every way their answer can go wrong.
    send_item(directed_item(REQ_BUILD, '0, 1'b0, 1'b1, 32'hFFFF_FFFF, '0, '0, '0, '0));
    send_item(directed_item(REQ_BUILD, '0, 1'b0, 1'b1, 32'h0, '0, '0, '0, '0));
    send_item(directed_item(REQ_CHECK, '0, 1'b0, 1'b1, 32'h1234_5678, RSP_TEST, '0,
                            TEST_REPLY_COUNT, 32'h1234_5678));
    send_item(directed_item(REQ_CHECK, '0, 1'b0, 1'b1, 32'h1234_5678, RSP_WORD_RD, '0,
                            TEST_REPLY_COUNT, 32'h1234_5678));
    send_item(directed_item(REQ_CHECK, '0, 1'b0, 1'b1, 32'h1234_5678, RSP_TEST, '0,
                            16'd5, 32'h1234_5678));
    send_item(directed_item(REQ_CHECK, '0, 1'b0, 1'b1, 32'h1234_5678, RSP_TEST, '0,
                            TEST_REPLY_COUNT, 32'h1234_5679));
    send_item('1);
    send_item('0);

    for (int p = 1; p <= NUM_PHASES; p++) begin
      drain();
      cfg_now = phase_cfg(p);
      program_regs(cfg_now);
      while (items_sent < 23 + 35 * p) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          run_transfer();
        end else if (r < 72) begin
          recovery_exchange();
        end else if (r < 96) begin
          send_item(random_item());
        end else begin
          drain();
        end
      end
    end

    // Let the last results out, then watch for stray ones.
    drain();
    repeat (SETTLE_CYCS) @(posedge clk_i);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
